// File: rtl/m4i_pkg.sv
// Package: widths, constants and types shared by the 4x4 inverse block.
`timescale 1ns / 1ps
`default_nettype none
package m4i_pkg;
  localparam int ElemW      = 32;
  localparam int FracBitsDef = 16;
  localparam int NumElems   = 16;
  localparam int ProdW      = 64;   // product of two elements
  localparam int CofW       = 98;   // 3x3 minor, exact
  localparam int DetW       = 132;  // 4x4 determinant, exact
  localparam int QuoW       = 33;   // quotient magnitude incl. overflow bit
endpackage
`default_nettype wire

// File: rtl/m4i_divider.sv
// Restoring divider: cofactor * 2^(2F) / det, truncated toward zero, saturated.
`timescale 1ns / 1ps
`default_nettype none
module m4i_divider
  import m4i_pkg::*;
#(
  parameter int FRACTION_BITS = FracBitsDef
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [CofW-1:0]  cof,
  input  wire logic signed [DetW-1:0]  det,
  output logic                         done,
  output logic        [ElemW-1:0]      quo
);
  localparam int NumW = CofW + 2 * FRACTION_BITS;
  localparam int RemW = DetW + 1;

  logic              busy_r;
  logic [7:0]        cnt_r;
  logic [NumW-1:0]   num_r;
  logic [RemW-1:0]   rem_r;
  logic [DetW-1:0]   dab_r;
  logic [QuoW-1:0]   q_r;
  logic              neg_r, ovf_r, done_r;

  logic [CofW-1:0]   cab;
  logic [DetW-1:0]   dab;
  logic [RemW-1:0]   rsh, rdif;
  logic [QuoW-1:0]   mag;
  logic [ElemW:0]    sgn;

  assign cab = cof[CofW-1] ? CofW'(-cof) : CofW'(cof);
  assign dab = det[DetW-1] ? DetW'(-det) : DetW'(det);
  assign rsh  = {rem_r[RemW-2:0], num_r[NumW-1]};
  assign rdif = rsh - {1'b0, dab_r};

  // one quotient bit a cycle; bits shifted out of the top set the overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == 8'd1);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 8'(NumW);
        num_r  <= NumW'(cab) << (2 * FRACTION_BITS);
        rem_r  <= '0;
        dab_r  <= dab;
        q_r    <= '0;
        neg_r  <= cof[CofW-1] ^ det[DetW-1];
        ovf_r  <= 1'b0;
      end else if (busy_r) begin
        num_r <= num_r << 1;
        if (!rdif[RemW-1]) begin
          rem_r <= rdif;
          if (q_r[QuoW-1]) ovf_r <= 1'b1;
          q_r <= {q_r[QuoW-2:0], 1'b1};
        end else begin
          rem_r <= rsh;
          if (q_r[QuoW-1]) ovf_r <= 1'b1;
          q_r <= {q_r[QuoW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 8'd1;
        if (cnt_r == 8'd1) busy_r <= 1'b0;
      end
    end
  end

  // saturate magnitude to signed range
  always_comb begin
    mag = ovf_r ? {1'b1, {(QuoW-1){1'b0}}} : q_r;
    if (neg_r) begin
      if (mag > QuoW'(33'h080000000)) mag = QuoW'(33'h080000000);
      sgn = (ElemW+1)'(-mag);
    end else begin
      if (mag > QuoW'(33'h07FFFFFFF)) mag = QuoW'(33'h07FFFFFFF);
      sgn = (ElemW+1)'(mag);
    end
  end
  assign quo  = sgn[ElemW-1:0];
  assign done = done_r;
endmodule
`default_nettype wire

// File: rtl/matrix4x4_inverse_cofactor.sv
// Top level: 4x4 matrix inverse by adjugate, Q-format fixed point.
// After the sixteenth element the block computes all cofactors and det, then divides each
//   cofactor in turn; each 3x3 term takes two serial multiplies, and a singular det skips the divide.
// Each further result is a 130-step divide plus handshake (no divide if singular).
// Elements are taken back to back; the next matrix is taken after the last result.
// Reset (rst_n low, synchronous) clears load count and control; store undefined.
`timescale 1ns / 1ps
`default_nettype none
module matrix4x4_inverse_cofactor
  import m4i_pkg::*;
#(
  parameter int FRACTION_BITS = FracBitsDef
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [ElemW-1:0] in_element_value,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [ElemW-1:0]      out_inverse_value,
  output logic                         out_singular,
  output logic                         out_last_of_run
);
  localparam int MagW = 4 * ElemW;  // magnitude of a wide operand, in 32-bit chunks

  typedef enum logic [3:0] {
    S_LOAD, S_RD, S_MUL, S_MWAIT, S_ACC, S_DET, S_DMUL, S_DWAIT, S_DIV, S_WAIT, S_OUT
  } state_t;

  state_t            st_r;
  logic [3:0]        cnt_r;
  // element store, one write and one read port, registered read
  logic [ElemW-1:0]  mem [NumElems];
  logic [ElemW-1:0]  rd_r;
  logic [3:0]        ra;
  // cofactor store
  logic signed [CofW-1:0] cof_mem [NumElems];
  logic signed [CofW-1:0] cof_rd_r;
  logic [3:0]        cwa_r;
  logic [3:0]        cra;
  // sequencing
  logic [3:0]        cof_r;     // cofactor index (inverse position i*4+j)
  logic [1:0]        term_r;    // term of 3x3 expansion
  logic [1:0]        fac_r;     // factor within the term
  logic [1:0]        tsel;
  logic [1:0]        pc;
  logic              pass_r;
  logic signed [CofW-1:0]  acc_r, prod_r;
  logic signed [DetW-1:0]  det_r;
  logic [1:0]        k_r;
  logic [4:0]        oi_r;
  logic              sing_r, last_r, dstart_r;
  logic [ElemW-1:0]  oval_r;
  logic              ov_r;
  logic              ddone;
  logic [ElemW-1:0]  dquo;
  logic [1:0] r0, r1, r2, c0, c1, c2, rr, cc, ri, ci;
  logic [1:0] skr, skc;
  logic              det_ph;
  // serial multiplier
  logic              mstart, mbusy_r, mfin_r, mdone_r, mneg_r;
  logic [1:0]        midx_r;
  logic signed [CofW-1:0] ma;
  logic [CofW-1:0]   maab;
  logic [ElemW-1:0]  mbab, mbmag_r, mchunk;
  logic [MagW-1:0]   mamag_r, macc_r, mpp_sh;
  logic [ProdW-1:0]  mpp;
  logic signed [DetW-1:0] mprod_r;

  assign skr = cof_r[1:0];   // skip row j
  assign skc = cof_r[3:2];   // skip column i
  assign r0 = (skr == 2'd0) ? 2'd1 : 2'd0;
  assign r1 = (skr <= 2'd1) ? 2'd2 : 2'd1;
  assign r2 = (skr == 2'd3) ? 2'd2 : 2'd3;
  assign c0 = (skc == 2'd0) ? 2'd1 : 2'd0;
  assign c1 = (skc <= 2'd1) ? 2'd2 : 2'd1;
  assign c2 = (skc == 2'd3) ? 2'd2 : 2'd3;

  // 3 even permutation terms of 3x3 det; tsel picks column for row fac_r
  always_comb begin
    pc = 2'd0;
    case ({term_r, fac_r})
      4'b00_00: pc = 2'd0; 4'b00_01: pc = 2'd1; 4'b00_10: pc = 2'd2;
      4'b01_00: pc = 2'd1; 4'b01_01: pc = 2'd2; 4'b01_10: pc = 2'd0;
      4'b10_00: pc = 2'd2; 4'b10_01: pc = 2'd0; 4'b10_10: pc = 2'd1;
      default:  pc = 2'd0;
    endcase
  end
  // second pass (odd permutations) uses swapped columns 1,2 of the above
  assign tsel = pass_r ? ((pc == 2'd1) ? 2'd2 : (pc == 2'd2) ? 2'd1 : 2'd0) : pc;
  assign rr = (fac_r == 2'd0) ? r0 : (fac_r == 2'd1) ? r1 : r2;
  assign cc = (tsel == 2'd0) ? c0 : (tsel == 2'd1) ? c1 : c2;
  assign det_ph = (st_r == S_DET) || (st_r == S_DMUL) || (st_r == S_DWAIT);
  assign ri = det_ph ? 2'd0 : rr;
  assign ci = det_ph ? k_r : cc;
  assign ra = {ri, ci};
  assign cra = det_ph ? {k_r, 2'd0} : oi_r[3:0];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[cnt_r] <= in_element_value;
    rd_r <= mem[ra];
  end
  always_ff @(posedge clk) begin
    if (st_r == S_ACC && fac_r == 2'd2 && term_r == 2'd2 && pass_r)
      cof_mem[cwa_r] <= (cof_r[0] ^ cof_r[2]) ? -(acc_r - prod_r) : (acc_r - prod_r);
    cof_rd_r <= cof_mem[cra];
  end

  // serial wide multiply: |a| in 32-bit chunks times |element| on one 32x32 multiplier
  assign mstart = ((st_r == S_MUL) && (fac_r != 2'd0)) || (st_r == S_DMUL);
  assign ma     = det_ph ? cof_rd_r : prod_r;
  assign maab   = ma[CofW-1] ? CofW'(-ma) : CofW'(ma);
  assign mbab   = rd_r[ElemW-1] ? ElemW'(-rd_r) : rd_r;
  always_comb begin
    case (midx_r)
      2'd0:    mchunk = mamag_r[ElemW-1:0];
      2'd1:    mchunk = mamag_r[2*ElemW-1:ElemW];
      2'd2:    mchunk = mamag_r[3*ElemW-1:2*ElemW];
      default: mchunk = mamag_r[MagW-1:3*ElemW];
    endcase
  end
  assign mpp    = mchunk * mbmag_r;
  assign mpp_sh = MagW'(mpp) << {midx_r, 5'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0; mfin_r <= 1'b0; mdone_r <= 1'b0;
    end else begin
      mfin_r  <= mbusy_r && (midx_r == 2'd3);
      mdone_r <= mfin_r;
      if (mstart) begin
        mbusy_r <= 1'b1;
        midx_r  <= '0;
        mamag_r <= MagW'(maab);
        mbmag_r <= mbab;
        mneg_r  <= ma[CofW-1] ^ rd_r[ElemW-1];
        macc_r  <= '0;
      end else if (mbusy_r) begin
        macc_r <= macc_r + mpp_sh;
        midx_r <= midx_r + 2'd1;
        if (midx_r == 2'd3) mbusy_r <= 1'b0;
      end
      if (mfin_r) mprod_r <= mneg_r ? -DetW'(macc_r) : DetW'(macc_r);
    end
  end

  m4i_divider #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart_r), .cof(cof_rd_r), .det(det_r),
    .done(ddone), .quo(dquo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; cnt_r <= '0; ov_r <= 1'b0; dstart_r <= 1'b0;
    end else begin
      dstart_r <= 1'b0;
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (st_r)
        S_LOAD: if (in_valid) begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            st_r <= S_RD; cof_r <= '0; term_r <= '0; fac_r <= '0;
            pass_r <= 1'b0; acc_r <= '0; cwa_r <= '0;
          end
        end
        S_RD: st_r <= S_MUL;
        S_MUL: begin
          // fac 0: load element; fac 1,2: serial multiply by the element
          if (fac_r == 2'd0) begin
            prod_r <= CofW'($signed(rd_r)); st_r <= S_ACC;
          end else st_r <= S_MWAIT;
        end
        S_MWAIT: if (mdone_r) begin
          prod_r <= CofW'(mprod_r); st_r <= S_ACC;
        end
        S_ACC: begin
          if (fac_r != 2'd2) begin
            fac_r <= fac_r + 2'd1; st_r <= S_RD;
          end else begin
            fac_r <= '0;
            if (term_r != 2'd2) begin
              acc_r <= pass_r ? acc_r - prod_r : acc_r + prod_r;
              term_r <= term_r + 2'd1; st_r <= S_RD;
            end else if (!pass_r) begin
              acc_r <= acc_r + prod_r;
              pass_r <= 1'b1; term_r <= '0; st_r <= S_RD;
            end else begin
              pass_r <= 1'b0; term_r <= '0; acc_r <= '0;
              cwa_r <= cof_r + 4'd1; cof_r <= cof_r + 4'd1;
              if (cof_r == 4'd15) begin
                st_r <= S_DET; k_r <= '0; det_r <= '0;
              end else st_r <= S_RD;
            end
          end
        end
        // determinant: row 0 times inverse column 0, reads settle during S_DET
        S_DET: st_r <= S_DMUL;
        S_DMUL: st_r <= S_DWAIT;
        S_DWAIT: if (mdone_r) begin
          det_r <= det_r + mprod_r;
          k_r <= k_r + 2'd1;
          if (k_r == 2'd3) begin
            st_r <= S_DIV; oi_r <= '0;
          end else st_r <= S_DET;
        end
        S_DIV: begin
          sing_r <= (det_r == '0);
          if (det_r == '0) st_r <= S_WAIT;
          else begin dstart_r <= 1'b1; st_r <= S_WAIT; end
        end
        S_WAIT: if (sing_r || ddone) begin
          oval_r <= sing_r ? ((oi_r[3:2] == oi_r[1:0]) ? ElemW'(1) << FRACTION_BITS : '0)
                           : dquo;
          last_r <= (oi_r == 5'd15);
          ov_r <= 1'b1;
          st_r <= S_OUT;
        end
        S_OUT: if (!ov_r || out_ready) begin
          if (oi_r == 5'd15) st_r <= S_LOAD;
          else begin oi_r <= oi_r + 5'd1; st_r <= S_DIV; end
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end

  assign in_ready          = (st_r == S_LOAD);
  assign out_valid         = ov_r;
  assign out_inverse_value = oval_r;
  assign out_singular      = sing_r;
  assign out_last_of_run   = last_r;
endmodule
`default_nettype wire

// File: test/tb.sv
// Testbench for the 4x4 fixed-point matrix inverse block.
`timescale 1ns / 1ps
module tb
  import m4i_pkg::*;
();

  localparam int Frac = FracBitsDef;

  typedef logic signed [191:0] wide_t;
  typedef struct packed {
    logic [31:0] value;
    logic        singular;
    logic        last;
  } inv_elem_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [ElemW-1:0] in_element_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [ElemW-1:0] out_inverse_value;
  logic out_singular;
  logic out_last_of_run;

  // predictor state
  logic [31:0] mat_shadow [16];
  int unsigned elem_count = 0;
  inv_elem_t inverse_q [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned matrices_sent = 0;
  int unsigned singular_seen = 0;

  always #5 clk = ~clk;

  matrix4x4_inverse_cofactor dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_inverse_value(out_inverse_value),
    .out_singular     (out_singular),
    .out_last_of_run  (out_last_of_run)
  );

  function automatic wide_t shadow_at(int r, int c);
    wide_t w;
    w = wide_t'($signed(mat_shadow[r*4 + c]));
    return w;
  endfunction

  // 3x3 determinant with one row and one column struck out
  function automatic wide_t minor_det(int skip_r, int skip_c);
    int rs [3];
    int cs [3];
    int k;
    wide_t e [3][3];
    k = 0;
    for (int t = 0; t < 4; t++) if (t != skip_r) begin
      rs[k] = t;
      k++;
    end
    k = 0;
    for (int t = 0; t < 4; t++) if (t != skip_c) begin
      cs[k] = t;
      k++;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) e[i][j] = shadow_at(rs[i], cs[j]);
    return e[0][0] * (e[1][1] * e[2][2] - e[1][2] * e[2][1])
         - e[0][1] * (e[1][0] * e[2][2] - e[1][2] * e[2][0])
         + e[0][2] * (e[1][0] * e[2][1] - e[1][1] * e[2][0]);
  endfunction

  // cof * 2^(2F) / det, truncated toward zero, saturated to 32 bits
  function automatic logic [31:0] fixed_quotient(wide_t cof, wide_t det);
    logic neg;
    wide_t a;
    logic [255:0] n, d, q;
    neg = cof[191] ^ det[191];
    n = '0;
    d = '0;
    a = cof[191] ? -cof : cof;
    n[191:0] = a;
    n = n << (2 * Frac);
    a = det[191] ? -det : det;
    d[191:0] = a;
    q = n / d;
    if (neg) begin
      if (q > 256'h8000_0000) q = 256'h8000_0000;
      return 32'd0 - q[31:0];
    end
    if (q > 256'h7FFF_FFFF) q = 256'h7FFF_FFFF;
    return q[31:0];
  endfunction

  // store an accepted element; on the sixteenth, queue the inverse
  function automatic void inverse_predict(logic [31:0] v);
    wide_t adj [16];
    wide_t det;
    inv_elem_t e;
    mat_shadow[elem_count] = v;
    if (elem_count != NumElems - 1) begin
      elem_count++;
      return;
    end
    elem_count = 0;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        adj[i*4 + j] = minor_det(j, i);
        if ((i + j) % 2 == 1) adj[i*4 + j] = -adj[i*4 + j];
      end
    det = '0;
    for (int k = 0; k < 4; k++) det = det + shadow_at(0, k) * adj[k*4];
    for (int k = 0; k < 16; k++) begin
      e.singular = (det == 0);
      e.last = (k == 15);
      if (e.singular) e.value = (k % 5 == 0) ? (32'd1 << Frac) : 32'd0;
      else e.value = fixed_quotient(adj[k], det);
      inverse_q.push_back(e);
    end
  endfunction

  // one element transfer, with optional idle cycles before it
  task automatic send_element(logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_element_value <= v;
    do @(posedge clk); while (!in_ready);
    inverse_predict(v);
    @(negedge clk);
  endtask

  task automatic send_matrix(logic [31:0] m [16]);
    for (int k = 0; k < 16; k++) send_element(m[k]);
    in_valid <= 1'b0;
    @(negedge clk);
    matrices_sent++;
  endtask

  // receiver stalls
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // result check
  always @(posedge clk) begin
    inv_elem_t exp_e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_singular) singular_seen++;
      if (inverse_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result value=%h", out_inverse_value);
      end else begin
        exp_e = inverse_q.pop_front();
        if (out_inverse_value !== exp_e.value || out_singular !== exp_e.singular ||
            out_last_of_run !== exp_e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h sing=%b last=%b, got %h sing=%b last=%b",
                     exp_e.value, exp_e.singular, exp_e.last,
                     out_inverse_value, out_singular, out_last_of_run);
        end
      end
    end
  end

  // extremes of the element range, mixed with small values
  task automatic test_extremes;
    logic [31:0] m [16];
    m = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
          32'h0001_0000, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
          32'hFFFF_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0002_8000,
          32'h0000_0003, 32'hFFFF_FFFE, 32'h8000_0001, 32'h5555_AAAA};
    send_matrix(m);
  endtask

  // zero determinant gives identity and the singular flag
  task automatic test_singular;
    logic [31:0] m [16];
    for (int k = 0; k < 16; k++) m[k] = '0;
    send_matrix(m);
  endtask

  task automatic random_matrix(output logic [31:0] m [16]);
    int kind;
    int a, b;
    kind = $urandom_range(4);
    for (int k = 0; k < 16; k++) begin
      case (kind)
        0: m[k] = $urandom();
        1: m[k] = $urandom_range(32'h0008_0000) - 32'h0004_0000;
        4: m[k] = ($urandom_range(8) - 4) << Frac;
        default: m[k] = $urandom_range(32'h0002_0000) - 32'h0001_0000;
      endcase
    end
    if (kind == 2) begin
      // copy one row onto another
      a = $urandom_range(3);
      b = (a + 1 + $urandom_range(2)) % 4;
      for (int c = 0; c < 4; c++) m[b*4 + c] = m[a*4 + c];
    end else if (kind == 3) begin
      // tiny diagonal so the inverse overflows
      for (int k = 0; k < 16; k++)
        m[k] = (k % 5 == 0) ? ($urandom_range(3) + 1) * ($urandom_range(1) ? 1 : -1)
                            : $urandom_range(2) - 1;
    end
  endtask

  task automatic test_random_phase(int unsigned idle, int unsigned stall, int count);
    logic [31:0] m [16];
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int n = 0; n < count; n++) begin
      random_matrix(m);
      send_matrix(m);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_extremes();
    test_singular();
    test_random_phase(0, 0, 4);
    test_random_phase(53, 0, 3);
    test_random_phase(0, 53, 4);
    test_random_phase(17, 17, 3);
    wait (inverse_q.size() == 0);
    repeat (600) @(posedge clk);
    $display("Sent %0d matrices; checked %0d inverse elements, %0d flagged singular.",
             matrices_sent, results_seen, singular_seen);
    $display("Phases: free flow, sender idle, receiver stall, both.");
    if (mismatches == 0 && inverse_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

// File: files.f
rtl/m4i_pkg.sv
rtl/m4i_divider.sv
rtl/matrix4x4_inverse_cofactor.sv
test/tb.sv
